>>> hdl/fde_pkg.sv
// Shared types, constants and helpers for the frame descriptor engine.
package fde_pkg;

    localparam int FDE_MAX_FRAME_LEN  = 4096;
    localparam int FDE_LOG_TABLE_BITS = 10;

    localparam int SAMPLE_W   = 16;
    localparam int ENERGY_W   = 43;
    localparam int ZCR_W      = 17;
    localparam int TEAGER_W   = 33;
    localparam int ENT_W      = 20;
    localparam int RATIO_W    = 24;

    localparam int ENERGY_LSB = 0;
    localparam int ZCR_LSB    = ENERGY_LSB + ENERGY_W;
    localparam int TEAGER_LSB = ZCR_LSB + ZCR_W;
    localparam int ENT_LSB    = TEAGER_LSB + TEAGER_W;
    localparam int JIT_LSB    = ENT_LSB + ENT_W;
    localparam int SHIM_LSB   = JIT_LSB + RATIO_W;
    localparam int FIELDS_W   = SHIM_LSB + RATIO_W;
    localparam int M_TDATA_W  = ((FIELDS_W + 7) / 8) * 8;

    localparam logic [ENERGY_W:0] ENERGY_MAX = {1'b0, {ENERGY_W{1'b1}}};
    localparam logic [ENT_W-1:0]  ENT_MAX    = {ENT_W{1'b1}};
    localparam logic [RATIO_W-1:0] Q816_MAX  = {RATIO_W{1'b1}};
    localparam logic [ZCR_W-1:0]  ZCR_ONE    = 17'h10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_ACC,
        ST_LOG_WAIT,
        ST_MLOG,
        ST_FIN_MUL,
        ST_FIN_LOG,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } fde_state_t;

    typedef enum logic [2:0] {
        DIV_ZCR,
        DIV_TEAGER,
        DIV_ENT,
        DIV_JIT,
        DIV_SHIM
    } fde_div_sel_t;

    typedef enum logic {
        LOG_SRC_SAMPLE,
        LOG_SRC_SUM
    } fde_log_src_t;

    typedef enum logic [1:0] {
        LOG_IDLE,
        LOG_NORM,
        LOG_SQ
    } fde_log_phase_t;

    typedef struct packed {
        logic         capture;
        logic         prod;
        logic         acc;
        logic         set_ovf;
        logic         log_start;
        fde_log_src_t log_src;
        logic         mlog_mul;
        logic         mlog_add;
        logic         fin_mul;
        logic         ent_log_cap;
        logic         div_start;
        logic         div_cap;
        fde_div_sel_t div_sel;
        logic         out_load;
    } fde_cmd_t;

    typedef struct packed {
        logic full;
        logic last_flag;
        logic log_done;
        logic div_done;
        logic out_busy;
    } fde_status_t;

    function automatic int fde_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> hdl/frame_descriptor_engine_core.sv
// Top level of the frame descriptor engine.
//
//   channel | dir | fields
//   --------+-----+-------------------------------------------------------------
//   s_*     | in  | tdata: sample[15:0]; tlast: end of frame
//   m_*     | out | tdata: energy, zcr, teager, entropy, jitter, shimmer; tuser: too_long
//
// A sample runs through capture, product, accumulate, log2 unit and log-product add;
// the log2 unit shifts the LW-bit |x|, LW = 16 + clog2(MAX_FRAME_LEN+1), up to its
// leading one and runs 16 squaring steps; a zero sample skips both. A last sample adds a
// log2 of the magnitude sum and five serial divisions of NUM_W + 1 bits, one per cycle.
// Reset clears all frame state at once. A waiting result stalls only the next frame's end.
module frame_descriptor_engine_core #(
    parameter int MAX_FRAME_LEN  = fde_pkg::FDE_MAX_FRAME_LEN,
    parameter int LOG_TABLE_BITS = fde_pkg::FDE_LOG_TABLE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // sample[15:0]
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // energy[42:0] zero_cross_rate[59:43] teager_mean[92:60] entropy[112:93]
    // jitter[136:113] shimmer[160:137] zero fill[167:161]
    output logic [fde_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser    // too_long
);

    fde_pkg::fde_cmd_t    cmd;
    fde_pkg::fde_status_t status;

    logic [fde_pkg::ENERGY_W-1:0] energy;
    logic [fde_pkg::ZCR_W-1:0]    zero_cross_rate;
    logic [fde_pkg::TEAGER_W-1:0] teager_mean;
    logic [fde_pkg::ENT_W-1:0]    entropy;
    logic [fde_pkg::RATIO_W-1:0]  jitter;
    logic [fde_pkg::RATIO_W-1:0]  shimmer;

    fde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    fde_datapath #(
        .MAX_FRAME_LEN  (MAX_FRAME_LEN),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .sample          (s_tdata),
        .last            (s_tlast),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .energy          (energy),
        .zero_cross_rate (zero_cross_rate),
        .teager_mean     (teager_mean),
        .entropy         (entropy),
        .jitter          (jitter),
        .shimmer         (shimmer),
        .too_long        (m_tuser)
    );

    assign m_tdata = {(fde_pkg::M_TDATA_W - fde_pkg::FIELDS_W)'(0),
                      shimmer, jitter, entropy, teager_mean, zero_cross_rate, energy};

endmodule

>>> hdl/fde_log.sv
// Iterative Q.16 log2 unit: leading-one search then sixteen squaring steps.
module fde_log #(
    parameter int LW             = 29,
    parameter int LOG_TABLE_BITS = fde_pkg::FDE_LOG_TABLE_BITS,
    parameter int LG_W           = $clog2(LW) + 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [LW-1:0]   m,
    output logic            done,
    output logic [LG_W-1:0] result
);

    localparam int EW = LG_W - 16;
    localparam logic [31:0] Y_ONE = 32'h4000_0000;

    fde_pkg::fde_log_phase_t phase_reg;
    logic                    done_reg;
    logic [LW-1:0]           norm_reg;
    logic [EW-1:0]           e_reg;
    logic [31:0]             y_reg;
    logic [15:0]             r_reg;
    logic [3:0]              step_reg;

    logic [63:0]               sq_full;
    logic [31:0]               sq_hi;
    logic                      ybit;
    logic [LOG_TABLE_BITS-1:0] idx;

    assign sq_full = y_reg * y_reg;
    assign sq_hi   = sq_full[61:30];
    assign ybit    = sq_hi[31];
    assign idx     = norm_reg[LW-2 -: LOG_TABLE_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fde_pkg::LOG_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (m == '0)
                begin
                    done_reg  <= 1'b1;
                    phase_reg <= fde_pkg::LOG_IDLE;
                end
                else
                begin
                    phase_reg <= fde_pkg::LOG_NORM;
                end
            end
            else
            begin
                unique case (phase_reg)
                    fde_pkg::LOG_IDLE:
                    begin
                        phase_reg <= fde_pkg::LOG_IDLE;
                    end
                    fde_pkg::LOG_NORM:
                    begin
                        if (norm_reg[LW-1])
                        begin
                            phase_reg <= fde_pkg::LOG_SQ;
                        end
                    end
                    fde_pkg::LOG_SQ:
                    begin
                        if (step_reg == 4'd15)
                        begin
                            phase_reg <= fde_pkg::LOG_IDLE;
                            done_reg  <= 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_reg <= fde_pkg::LOG_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            norm_reg <= m;
            e_reg    <= (m == '0) ? '0 : EW'(LW - 1);
            r_reg    <= '0;
        end
        else if (phase_reg == fde_pkg::LOG_NORM)
        begin
            if (norm_reg[LW-1])
            begin
                y_reg    <= Y_ONE + (32'(idx) << (30 - LOG_TABLE_BITS));
                r_reg    <= '0;
                step_reg <= '0;
            end
            else
            begin
                norm_reg <= norm_reg << 1;
                e_reg    <= e_reg - EW'(1);
            end
        end
        else if (phase_reg == fde_pkg::LOG_SQ)
        begin
            y_reg    <= ybit ? (sq_hi >> 1) : sq_hi;
            r_reg    <= {r_reg[14:0], ybit};
            step_reg <= step_reg + 4'd1;
        end
    end

    assign done   = done_reg;
    assign result = {e_reg, r_reg};

endmodule

>>> hdl/fde_div.sv
// Restoring divider, one quotient bit per cycle, rounds to nearest.
module fde_div #(
    parameter int NUM_W = 57,
    parameter int DEN_W = 41
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W:0]   quot
);

    localparam int CW = $clog2(NUM_W + 2);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NUM_W:0]   n_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0] rem_sh;
    logic           ge;

    assign rem_sh = {rem_reg, n_reg[NUM_W]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(NUM_W + 1);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= (den == '0) ? '0 : ((NUM_W+1)'(num) + (NUM_W+1)'(den >> 1));
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
            n_reg   <= {n_reg[NUM_W-1:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = n_reg;

endmodule

>>> hdl/fde_datapath.sv
// Datapath: frame accumulators, end-of-frame arithmetic and result register.
module fde_datapath #(
    parameter int MAX_FRAME_LEN  = fde_pkg::FDE_MAX_FRAME_LEN,
    parameter int LOG_TABLE_BITS = fde_pkg::FDE_LOG_TABLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fde_pkg::fde_cmd_t                   cmd,
    output fde_pkg::fde_status_t                status,
    input  logic signed [fde_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [fde_pkg::ENERGY_W-1:0]        energy,
    output logic [fde_pkg::ZCR_W-1:0]           zero_cross_rate,
    output logic [fde_pkg::TEAGER_W-1:0]        teager_mean,
    output logic [fde_pkg::ENT_W-1:0]           entropy,
    output logic [fde_pkg::RATIO_W-1:0]         jitter,
    output logic [fde_pkg::RATIO_W-1:0]         shimmer,
    output logic                                too_long
);

    localparam int CNT_W     = $clog2(MAX_FRAME_LEN + 1);
    localparam int MAG_W     = 16 + CNT_W;
    localparam int AMP_SUM_W = 15 + CNT_W;
    localparam int PCS_W     = 2 * CNT_W;
    localparam int TEA_W     = 33 + CNT_W;
    localparam int MLS_W     = 35 + CNT_W;
    localparam int LG_W      = $clog2(MAG_W) + 16;
    localparam int JNUM_W    = PCS_W + CNT_W;
    localparam int JDEN_W    = 2 * CNT_W;
    localparam int SNUM_W    = AMP_SUM_W + CNT_W;
    localparam int SDEN_W    = AMP_SUM_W + CNT_W;
    localparam int NUM_W     = fde_pkg::fde_max(MLS_W,
                                   fde_pkg::fde_max(JNUM_W + 16, SNUM_W + 16));
    localparam int DEN_W     = SDEN_W;
    localparam int Q_W       = NUM_W + 1;

    // sample and product stage
    logic signed [15:0] x_reg;
    logic               last_reg;
    logic [15:0]        mag_reg;
    logic [30:0]        sq_reg;
    logic signed [32:0] term_reg;
    logic [34:0]        mlog_prod_reg;

    // frame state
    logic signed [15:0]     prev_reg;
    logic signed [15:0]     prev2_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cross_reg;
    logic [fde_pkg::ENERGY_W-1:0] sqsum_reg;
    logic signed [TEA_W-1:0] tsum_reg;
    logic [MAG_W-1:0]       msum_reg;
    logic [MLS_W-1:0]       mls_reg;
    logic [CNT_W-1:0]       pk_reg;
    logic [CNT_W-1:0]       first_reg;
    logic [CNT_W-1:0]       lastidx_reg;
    logic [CNT_W-1:0]       lastper_reg;
    logic [PCS_W-1:0]       pcs_reg;
    logic [AMP_SUM_W-1:0]   psum_reg;
    logic [14:0]            lastamp_reg;
    logic [AMP_SUM_W-1:0]   acs_reg;
    logic                   ovf_reg;

    // end-of-frame terms and results
    logic [JNUM_W-1:0]      jnum_reg;
    logic [JDEN_W-1:0]      jden_reg;
    logic [SNUM_W-1:0]      snum_reg;
    logic [SDEN_W-1:0]      sden_reg;
    logic [TEA_W-1:0]       tabs_reg;
    logic                   tneg_reg;
    logic [LG_W-1:0]        lgt_reg;
    logic [fde_pkg::ZCR_W-1:0]    zcr_res_reg;
    logic [fde_pkg::TEAGER_W-1:0] tq_res_reg;
    logic [fde_pkg::ENT_W-1:0]    ent_res_reg;
    logic [fde_pkg::RATIO_W-1:0]  jit_res_reg;
    logic [fde_pkg::RATIO_W-1:0]  shim_res_reg;

    // result register
    logic                         out_valid_reg;
    logic [fde_pkg::ENERGY_W-1:0] energy_out_reg;
    logic [fde_pkg::ZCR_W-1:0]    zcr_out_reg;
    logic [fde_pkg::TEAGER_W-1:0] tq_out_reg;
    logic [fde_pkg::ENT_W-1:0]    ent_out_reg;
    logic [fde_pkg::RATIO_W-1:0]  jit_out_reg;
    logic [fde_pkg::RATIO_W-1:0]  shim_out_reg;
    logic                         ovf_out_reg;

    // product stage logic
    logic [15:0]        mag;
    logic [31:0]        sq_full;
    logic signed [31:0] pp;
    logic signed [31:0] cr;
    logic signed [32:0] term;

    assign mag     = x_reg[15] ? 16'(-x_reg) : 16'(x_reg);
    assign sq_full = mag * mag;
    assign pp      = prev_reg * prev_reg;
    assign cr      = prev2_reg * x_reg;
    assign term    = 33'(pp) - 33'(cr);

    // accumulate logic
    logic [fde_pkg::ENERGY_W:0] sq_wide;
    logic                       is_cross;
    logic                       is_peak;
    logic [CNT_W-1:0]           pk_idx;
    logic [CNT_W-1:0]           per;
    logic [CNT_W-1:0]           per_diff;
    logic [14:0]                amp;
    logic [14:0]                amp_diff;

    assign sq_wide  = {1'b0, sqsum_reg} + (fde_pkg::ENERGY_W+1)'(sq_reg);
    assign is_cross = (cnt_reg >= CNT_W'(1)) && (x_reg[15] != prev_reg[15]);
    assign is_peak  = (cnt_reg >= CNT_W'(2)) && (prev_reg > prev2_reg)
                      && (prev_reg >= x_reg) && (prev_reg > 16'sd0);
    assign pk_idx   = cnt_reg - CNT_W'(1);
    assign per      = pk_idx - lastidx_reg;
    assign per_diff = (per > lastper_reg) ? (per - lastper_reg) : (lastper_reg - per);
    assign amp      = prev_reg[14:0];
    assign amp_diff = (amp > lastamp_reg) ? (amp - lastamp_reg) : (lastamp_reg - amp);

    // log unit
    logic [MAG_W-1:0] log_m;
    logic             log_done;
    logic [LG_W-1:0]  log_result;
    logic [15+LG_W:0] mlog_full;

    assign log_m     = (cmd.log_src == fde_pkg::LOG_SRC_SUM) ? msum_reg : MAG_W'(mag_reg);
    assign mlog_full = mag_reg * log_result;

    fde_log #(
        .LW             (MAG_W),
        .LOG_TABLE_BITS (LOG_TABLE_BITS),
        .LG_W           (LG_W)
    ) u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.log_start),
        .m      (log_m),
        .done   (log_done),
        .result (log_result)
    );

    // end-of-frame products
    logic [JNUM_W-1:0] jnum_c;
    logic [JDEN_W-1:0] jden_c;
    logic [SNUM_W-1:0] snum_c;
    logic [SDEN_W-1:0] sden_c;
    logic [CNT_W-1:0]  span;

    assign span   = lastidx_reg - first_reg;
    assign jnum_c = pcs_reg * (pk_reg - CNT_W'(1));
    assign jden_c = (pk_reg - CNT_W'(2)) * span;
    assign snum_c = acs_reg * pk_reg;
    assign sden_c = (pk_reg - CNT_W'(1)) * psum_reg;

    // divider
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [Q_W-1:0]   quot;
    logic             n_ge2;
    logic             n_ge3;
    logic             k_ge3;

    assign n_ge2 = cnt_reg >= CNT_W'(2);
    assign n_ge3 = cnt_reg >= CNT_W'(3);
    assign k_ge3 = pk_reg >= CNT_W'(3);

    always_comb
    begin
        unique case (cmd.div_sel)
            fde_pkg::DIV_ZCR:
            begin
                div_num = NUM_W'({cross_reg, 16'd0});
                div_den = n_ge2 ? DEN_W'(cnt_reg - CNT_W'(1)) : '0;
            end
            fde_pkg::DIV_TEAGER:
            begin
                div_num = NUM_W'(tabs_reg);
                div_den = n_ge3 ? DEN_W'(cnt_reg - CNT_W'(2)) : '0;
            end
            fde_pkg::DIV_ENT:
            begin
                div_num = NUM_W'(mls_reg);
                div_den = DEN_W'(msum_reg);
            end
            fde_pkg::DIV_JIT:
            begin
                div_num = NUM_W'({jnum_reg, 16'd0});
                div_den = k_ge3 ? DEN_W'(jden_reg) : '0;
            end
            fde_pkg::DIV_SHIM:
            begin
                div_num = NUM_W'({snum_reg, 16'd0});
                div_den = k_ge3 ? DEN_W'(sden_reg) : '0;
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    fde_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    // result shaping
    logic [32:0]     q_t;
    logic [LG_W-1:0] ent_diff;

    assign q_t      = quot[32:0];
    assign ent_diff = lgt_reg - quot[LG_W-1:0];

    // sample, product, end-of-frame and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg    <= sample;
            last_reg <= last;
        end
        if (cmd.prod)
        begin
            mag_reg  <= mag;
            sq_reg   <= sq_full[30:0];
            term_reg <= term;
        end
        if (cmd.mlog_mul)
        begin
            mlog_prod_reg <= mlog_full[34:0];
        end
        if (cmd.fin_mul)
        begin
            jnum_reg <= jnum_c;
            jden_reg <= jden_c;
            snum_reg <= snum_c;
            sden_reg <= sden_c;
            tneg_reg <= tsum_reg[TEA_W-1];
            tabs_reg <= tsum_reg[TEA_W-1] ? TEA_W'(-tsum_reg) : TEA_W'(tsum_reg);
        end
        if (cmd.ent_log_cap)
        begin
            lgt_reg <= log_result;
        end
        if (cmd.div_cap)
        begin
            unique case (cmd.div_sel)
                fde_pkg::DIV_ZCR:
                begin
                    zcr_res_reg <= quot[fde_pkg::ZCR_W-1:0];
                end
                fde_pkg::DIV_TEAGER:
                begin
                    tq_res_reg <= tneg_reg ? (~q_t + 33'd1) : q_t;
                end
                fde_pkg::DIV_ENT:
                begin
                    if (quot >= Q_W'(lgt_reg))
                    begin
                        ent_res_reg <= '0;
                    end
                    else if (ent_diff > LG_W'(fde_pkg::ENT_MAX))
                    begin
                        ent_res_reg <= fde_pkg::ENT_MAX;
                    end
                    else
                    begin
                        ent_res_reg <= ent_diff[fde_pkg::ENT_W-1:0];
                    end
                end
                fde_pkg::DIV_JIT:
                begin
                    jit_res_reg <= (quot > Q_W'(fde_pkg::Q816_MAX))
                                   ? fde_pkg::Q816_MAX : quot[fde_pkg::RATIO_W-1:0];
                end
                fde_pkg::DIV_SHIM:
                begin
                    shim_res_reg <= (quot > Q_W'(fde_pkg::Q816_MAX))
                                    ? fde_pkg::Q816_MAX : quot[fde_pkg::RATIO_W-1:0];
                end
                default:
                begin
                    zcr_res_reg <= zcr_res_reg;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            energy_out_reg <= sqsum_reg;
            zcr_out_reg    <= zcr_res_reg;
            tq_out_reg     <= tq_res_reg;
            ent_out_reg    <= ent_res_reg;
            jit_out_reg    <= jit_res_reg;
            shim_out_reg   <= shim_res_reg;
            ovf_out_reg    <= ovf_reg;
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            prev2_reg   <= '0;
            cnt_reg     <= '0;
            cross_reg   <= '0;
            sqsum_reg   <= '0;
            tsum_reg    <= '0;
            msum_reg    <= '0;
            mls_reg     <= '0;
            pk_reg      <= '0;
            first_reg   <= '0;
            lastidx_reg <= '0;
            lastper_reg <= '0;
            pcs_reg     <= '0;
            psum_reg    <= '0;
            lastamp_reg <= '0;
            acs_reg     <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            prev_reg    <= '0;
            prev2_reg   <= '0;
            cnt_reg     <= '0;
            cross_reg   <= '0;
            sqsum_reg   <= '0;
            tsum_reg    <= '0;
            msum_reg    <= '0;
            mls_reg     <= '0;
            pk_reg      <= '0;
            first_reg   <= '0;
            lastidx_reg <= '0;
            lastper_reg <= '0;
            pcs_reg     <= '0;
            psum_reg    <= '0;
            lastamp_reg <= '0;
            acs_reg     <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.mlog_add)
            begin
                mls_reg <= mls_reg + MLS_W'(mlog_prod_reg);
            end
            if (cmd.acc)
            begin
                sqsum_reg <= (sq_wide > fde_pkg::ENERGY_MAX)
                             ? fde_pkg::ENERGY_W'(fde_pkg::ENERGY_MAX)
                             : sq_wide[fde_pkg::ENERGY_W-1:0];
                msum_reg  <= msum_reg + MAG_W'(mag_reg);
                if (is_cross)
                begin
                    cross_reg <= cross_reg + CNT_W'(1);
                end
                if (cnt_reg >= CNT_W'(2))
                begin
                    tsum_reg <= tsum_reg + TEA_W'(term_reg);
                end
                if (is_peak)
                begin
                    if (pk_reg == '0)
                    begin
                        first_reg <= pk_idx;
                    end
                    else
                    begin
                        if (pk_reg >= CNT_W'(2))
                        begin
                            pcs_reg <= pcs_reg + PCS_W'(per_diff);
                        end
                        lastper_reg <= per;
                        acs_reg     <= acs_reg + AMP_SUM_W'(amp_diff);
                    end
                    lastidx_reg <= pk_idx;
                    lastamp_reg <= amp;
                    psum_reg    <= psum_reg + AMP_SUM_W'(amp);
                    pk_reg      <= pk_reg + CNT_W'(1);
                end
                prev2_reg <= prev_reg;
                prev_reg  <= x_reg;
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.full      = cnt_reg >= CNT_W'(MAX_FRAME_LEN);
    assign status.last_flag = last_reg;
    assign status.log_done  = log_done;
    assign status.div_done  = div_done;
    assign status.out_busy  = out_valid_reg & ~out_ready;

    assign out_valid       = out_valid_reg;
    assign energy          = energy_out_reg;
    assign zero_cross_rate = zcr_out_reg;
    assign teager_mean     = tq_out_reg;
    assign entropy         = ent_out_reg;
    assign jitter          = jit_out_reg;
    assign shimmer         = shim_out_reg;
    assign too_long        = ovf_out_reg;

endmodule

>>> hdl/fde_ctrl.sv
// Controller: sequences per-sample accumulation and end-of-frame steps.
module fde_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output fde_pkg::fde_cmd_t    cmd,
    input  fde_pkg::fde_status_t status
);

    fde_pkg::fde_state_t   state_reg;
    fde_pkg::fde_state_t   state_next;
    fde_pkg::fde_div_sel_t sel_reg;
    fde_pkg::fde_div_sel_t sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fde_pkg::ST_IDLE;
            sel_reg   <= fde_pkg::DIV_ZCR;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.log_src = fde_pkg::LOG_SRC_SAMPLE;
        cmd.div_sel = sel_reg;
        s_tready    = 1'b0;
        state_next  = state_reg;
        sel_next    = sel_reg;
        unique case (state_reg)
            fde_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = fde_pkg::ST_PROD;
                end
            end
            fde_pkg::ST_PROD:
            begin
                if (status.full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = status.last_flag ? fde_pkg::ST_FIN_MUL : fde_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.prod   = 1'b1;
                    state_next = fde_pkg::ST_ACC;
                end
            end
            fde_pkg::ST_ACC:
            begin
                cmd.acc       = 1'b1;
                cmd.log_start = 1'b1;
                state_next    = fde_pkg::ST_LOG_WAIT;
            end
            fde_pkg::ST_LOG_WAIT:
            begin
                if (status.log_done)
                begin
                    cmd.mlog_mul = 1'b1;
                    state_next   = fde_pkg::ST_MLOG;
                end
            end
            fde_pkg::ST_MLOG:
            begin
                cmd.mlog_add = 1'b1;
                state_next   = status.last_flag ? fde_pkg::ST_FIN_MUL : fde_pkg::ST_IDLE;
            end
            fde_pkg::ST_FIN_MUL:
            begin
                cmd.fin_mul   = 1'b1;
                cmd.log_start = 1'b1;
                cmd.log_src   = fde_pkg::LOG_SRC_SUM;
                state_next    = fde_pkg::ST_FIN_LOG;
            end
            fde_pkg::ST_FIN_LOG:
            begin
                if (status.log_done)
                begin
                    cmd.ent_log_cap = 1'b1;
                    sel_next        = fde_pkg::DIV_ZCR;
                    state_next      = fde_pkg::ST_DIV_START;
                end
            end
            fde_pkg::ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = fde_pkg::ST_DIV_WAIT;
            end
            fde_pkg::ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_cap = 1'b1;
                    state_next  = fde_pkg::ST_DIV_START;
                    unique case (sel_reg)
                        fde_pkg::DIV_ZCR:    sel_next = fde_pkg::DIV_TEAGER;
                        fde_pkg::DIV_TEAGER: sel_next = fde_pkg::DIV_ENT;
                        fde_pkg::DIV_ENT:    sel_next = fde_pkg::DIV_JIT;
                        fde_pkg::DIV_JIT:    sel_next = fde_pkg::DIV_SHIM;
                        fde_pkg::DIV_SHIM:   state_next = fde_pkg::ST_OUT;
                        default:             state_next = fde_pkg::ST_OUT;
                    endcase
                end
            end
            fde_pkg::ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = fde_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fde_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/fde_checker.sv
// Port-level checks for the frame descriptor engine, bound to the top level.
module fde_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [fde_pkg::M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous sample in work");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready ##1 !s_tready)
        else $error("frame end released input too early");

    a_zcr_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[fde_pkg::ZCR_LSB +: fde_pkg::ZCR_W] <= fde_pkg::ZCR_ONE)
        else $error("zero-crossing rate above one");

endmodule

bind frame_descriptor_engine_core fde_checker u_fde_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/fde_checker.sv
// Checker for the frame descriptor engine: predicts each frame's descriptors and compares.
`timescale 1ns / 1ps

module fde_scoreboard
    import fde_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [15:0]          s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tuser,
    output int                   errors,
    output int                   pending
);

    typedef struct {
        logic [ENERGY_W-1:0] energy;
        logic [ZCR_W-1:0]    zcr;
        logic [TEAGER_W-1:0] teager;
        logic [ENT_W-1:0]    ent;
        logic [RATIO_W-1:0]  jit;
        logic [RATIO_W-1:0]  shim;
        logic                too_long;
    } descr_t;

    descr_t descr_q[$];

    int                   prv, prv2;
    int unsigned          n_smp, n_cross, n_peak, pk_first, pk_last, per_last, amp_last;
    longint unsigned      sq_sum, mag_sum, mlog_sum, per_chg, amp_sum, amp_chg;
    longint               tk_sum;
    bit                   ovf;

    function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
        if (den == 0)
            return 0;
        return (num + den / 2) / den;
    endfunction

    function automatic longint unsigned log2_q16(longint unsigned m);
        longint unsigned mask, idx, y, r;
        int e;
        mask = (64'd1 << FDE_LOG_TABLE_BITS) - 1;
        if (m == 0)
            return 0;
        e = 0;
        while (e < 63 && (m >> (e + 1)) != 0)
            e++;
        if (e >= FDE_LOG_TABLE_BITS)
            idx = (m >> (e - FDE_LOG_TABLE_BITS)) & mask;
        else
            idx = (m << (FDE_LOG_TABLE_BITS - e)) & mask;
        y = (64'd1 << 30) + (idx << (30 - FDE_LOG_TABLE_BITS));
        r = 0;
        for (int k = 0; k < 16; k++)
        begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd2 << 30))
            begin
                r = r | 1;
                y = y >> 1;
            end
        end
        return (longint'(e) << 16) + r;
    endfunction

    function automatic longint unsigned sat24(longint unsigned v);
        return (v > longint'(Q816_MAX)) ? longint'(Q816_MAX) : v;
    endfunction

    task automatic clear_frame();
        prv = 0; prv2 = 0;
        n_smp = 0; n_cross = 0; n_peak = 0; pk_first = 0; pk_last = 0; per_last = 0;
        amp_last = 0;
        sq_sum = 0; mag_sum = 0; mlog_sum = 0; per_chg = 0; amp_sum = 0; amp_chg = 0;
        tk_sum = 0; ovf = 0;
    endtask

    task automatic accumulate(int x);
        int unsigned mag, idx, per;
        mag = (x < 0) ? -x : x;
        sq_sum += longint'(mag) * mag;
        if (sq_sum > longint'(ENERGY_MAX))
            sq_sum = ENERGY_MAX;
        mag_sum += mag;
        if (mag != 0)
            mlog_sum += longint'(mag) * log2_q16(mag);
        if (n_smp >= 1 && ((x >= 0) != (prv >= 0)))
            n_cross++;
        if (n_smp >= 2)
        begin
            tk_sum += longint'(prv) * prv - longint'(prv2) * x;
            if (prv > prv2 && prv >= x && prv > 0)
            begin
                idx = n_smp - 1;
                if (n_peak == 0)
                    pk_first = idx;
                else
                begin
                    per = idx - pk_last;
                    if (n_peak >= 2)
                        per_chg += (per > per_last) ? per - per_last : per_last - per;
                    per_last = per;
                    amp_chg += (prv > amp_last) ? prv - amp_last : amp_last - prv;
                end
                pk_last = idx;
                amp_last = prv;
                amp_sum += prv;
                n_peak++;
            end
        end
        prv2 = prv;
        prv = x;
        n_smp++;
    endtask

    task automatic close_frame();
        descr_t d;
        longint unsigned q, a, k;
        longint h;
        d.energy = ENERGY_W'(sq_sum);
        d.zcr = (n_smp >= 2) ? ZCR_W'(rdiv(longint'(n_cross) << 16, n_smp - 1)) : '0;
        d.teager = 0;
        if (n_smp >= 3)
        begin
            a = (tk_sum < 0) ? -tk_sum : tk_sum;
            q = rdiv(a, n_smp - 2);
            d.teager = (tk_sum < 0) ? TEAGER_W'(-q) : TEAGER_W'(q);
        end
        d.ent = 0;
        if (mag_sum != 0)
        begin
            h = longint'(log2_q16(mag_sum)) - longint'(rdiv(mlog_sum, mag_sum));
            if (h < 0)
                h = 0;
            if (h > longint'(ENT_MAX))
                h = ENT_MAX;
            d.ent = ENT_W'(h);
        end
        d.jit = 0;
        d.shim = 0;
        if (n_peak >= 3)
        begin
            k = n_peak;
            d.jit = RATIO_W'(sat24(rdiv((per_chg * (k - 1)) << 16,
                                        (k - 2) * (pk_last - pk_first))));
            d.shim = RATIO_W'(sat24(rdiv((amp_chg * k) << 16, (k - 1) * amp_sum)));
        end
        d.too_long = ovf;
        descr_q.insert(descr_q.size(), d);
        clear_frame();
    endtask

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        clear_frame();
    end

    always @(posedge clk)
    begin
        descr_t e;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (n_smp < FDE_MAX_FRAME_LEN)
                    accumulate(int'($signed(s_tdata)));
                else
                    ovf = 1;
                if (s_tlast)
                    close_frame();
            end
            if (m_tvalid && m_tready)
            begin
                if (descr_q.size() == 0)
                    report("unexpected result", m_tdata[ENERGY_W-1:0], 0);
                else
                begin
                    e = descr_q.pop_front();
                    if (m_tdata[ENERGY_LSB +: ENERGY_W] != e.energy)
                        report("energy", m_tdata[ENERGY_LSB +: ENERGY_W], e.energy);
                    if (m_tdata[ZCR_LSB +: ZCR_W] != e.zcr)
                        report("zero_cross_rate", m_tdata[ZCR_LSB +: ZCR_W], e.zcr);
                    if (m_tdata[TEAGER_LSB +: TEAGER_W] != e.teager)
                        report("teager_mean", m_tdata[TEAGER_LSB +: TEAGER_W], e.teager);
                    if (m_tdata[ENT_LSB +: ENT_W] != e.ent)
                        report("entropy", m_tdata[ENT_LSB +: ENT_W], e.ent);
                    if (m_tdata[JIT_LSB +: RATIO_W] != e.jit)
                        report("jitter", m_tdata[JIT_LSB +: RATIO_W], e.jit);
                    if (m_tdata[SHIM_LSB +: RATIO_W] != e.shim)
                        report("shimmer", m_tdata[SHIM_LSB +: RATIO_W], e.shim);
                    if (m_tuser != e.too_long)
                        report("too_long", m_tuser, e.too_long);
                end
            end
            pending = descr_q.size();
        end
    end

endmodule

>>> verif/tb_frame_descriptor_engine_core.sv
// Testbench top for the frame descriptor engine: clock, reset, sample stimulus, verdict.
`timescale 1ns / 1ps

module tb_frame_descriptor_engine_core;
    import fde_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int errors;
    int pending;
    int n_sent;
    int hold_left;
    int cycles;
    bit idle_en;

    frame_descriptor_engine_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fde_scoreboard chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: long hold-off when requested, else random stalls while idle_en is set
    initial
    begin
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 0;
                hold_left--;
            end
            else
                m_tready <= !(idle_en && $urandom_range(99) < 18);
        end
    end

    task automatic send_sample(int x, bit lst);
        while (idle_en && $urandom_range(99) < 18)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= x[15:0];
        s_tlast  <= lst;
        n_sent++;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    function automatic int clip16(int v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    // kind: 0 full-range noise, 1 periodic wave with peak jitter, 2 small noise,
    // 3 alternating extremes
    task automatic send_frame(int len, int kind);
        int per, ph, amp, x;
        per = $urandom_range(20, 2);
        amp = $urandom_range(32767, 1);
        ph = 0;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                0: x = int'($urandom_range(65535)) - 32768;
                1:
                begin
                    x = amp * (2 * ph - per) / per;
                    x = (x < 0) ? -x : x;
                    x = clip16(amp / 2 - x + int'($urandom_range(16)) - 8);
                    ph++;
                    if (ph >= per)
                    begin
                        ph = 0;
                        if ($urandom_range(3) == 0)
                            per = $urandom_range(20, 2);
                        if ($urandom_range(3) == 0)
                            amp = $urandom_range(32767, 1);
                    end
                end
                2: x = int'($urandom_range(8)) - 4;
                default: x = (i % 2) ? -32768 : 32767;
            endcase
            send_sample(x, i == len - 1);
        end
    endtask

    initial
    begin
        int len, kind;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        hold_left = 0;
        idle_en = 1;
        n_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_sample(-32768, 1);
        send_sample(0, 1);
        send_sample(32767, 0);
        send_sample(-32768, 1);
        send_sample(0, 0);
        send_sample(0, 0);
        send_sample(0, 1);
        send_sample(100, 0);
        send_sample(-100, 0);
        send_sample(100, 1);
        send_sample(1, 0);
        send_sample(5, 0);
        send_sample(2, 0);
        send_sample(6, 0);
        send_sample(6, 0);
        send_sample(1, 0);
        send_sample(9, 0);
        send_sample(-1, 0);
        send_sample(7, 0);
        send_sample(0, 1);

        while (n_sent < 1400)
        begin
            if (n_sent > 300 && n_sent < 360)
                idle_en = 0;
            else
                idle_en = 1;
            kind = $urandom_range(9);
            kind = (kind < 5) ? 1 : ((kind < 7) ? 0 : ((kind < 9) ? 2 : 3));
            len = ($urandom_range(15) == 0) ? $urandom_range(200, 60) : $urandom_range(40, 1);
            send_frame(len, kind);
            if ($urandom_range(40) == 0)
            begin
                s_tvalid <= 0;
                @(posedge clk);
                wait (pending == 0);
            end
        end

        hold_left = 3000;
        repeat (6) send_frame(3, 0);

        send_frame(5, 1);

        s_tvalid <= 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
hdl/fde_pkg.sv
hdl/fde_log.sv
hdl/fde_div.sv
hdl/fde_datapath.sv
hdl/fde_ctrl.sv
hdl/frame_descriptor_engine_core.sv
hdl/fde_checker.sv
verif/fde_checker.sv
verif/tb_frame_descriptor_engine_core.sv
